@@ hw/rtl/otsu_pkg.sv @@
// Shared constants for the Otsu threshold finder.
package otsu_pkg;

  localparam int unsigned LevelBits = 8;
  localparam int unsigned NumLevels = 256;
  localparam logic [LevelBits-1:0] MaxLevel = 8'd255;

endpackage

@@ hw/rtl/otsu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module otsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/otsu_threshold_finder.sv @@
// Otsu threshold finder: 256-bin histogram and exact integer threshold search.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] pixel, tlast last_pixel
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[7:0] threshold
//
//  After reset a clearing pass writes zero to all 256 bins, not ready meanwhile.
//  Each pixel word is a histogram read, then a write back of count + 1.
//  After a last-pixel word, the scan visits 256 levels; each level passes S_SRD,
//  S_SACC, S_SCHK and S_STEP, and a level with both classes nonempty also runs six
//  products on one shift-add multiplier before S_STEP; then S_OUT presents the
//  result once the output is free.
//  The scan clears each bin as it reads it. A waiting result does not block the
//  next image; only a second result with the first still untaken waits.
module otsu_threshold_finder #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] threshold
);

  localparam int unsigned LB = otsu_pkg::LevelBits;
  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned SB = CB + LB;          // intensity sums
  localparam int unsigned PB = CB + SB;          // cross products and their difference
  localparam int unsigned NB = 2 * PB;           // numerator
  localparam int unsigned DB = 2 * CB;           // denominator
  localparam int unsigned XB = NB + DB;          // cross-multiplied compare
  localparam int unsigned NW = $clog2(PB + 1);
  localparam logic [CB-1:0] CountMax = {CB{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INC, S_SRD, S_SACC, S_SCHK, S_MUL, S_NEXT, S_STEP, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_P, OP_Q, OP_NUM, OP_DEN, OP_LHS, OP_RHS
  } op_e;

  state_e state_q;
  op_e    op_q;

  logic [LB-1:0] clr_q, k_q, pix_q, best_q;
  logic          last_q, cnt_ok_q;
  logic [CB-1:0] n_q, w1_q;
  logic [SB-1:0] s_q, s1_q;
  logic [PB-1:0] p_q;
  logic [NB-1:0] num_q, best_num_q;
  logic [DB-1:0] den_q, best_den_q;
  logic [XB-1:0] lhs_q;

  // shared shift-add multiplier
  logic [XB-1:0] mc_q, acc_q;
  logic [PB-1:0] mp_q;
  logic [NW-1:0] mcnt_q;

  logic          m_valid_q;
  logic [LB-1:0] m_data_q;

  logic          ram_we;
  logic [LB-1:0] ram_waddr, ram_raddr;
  logic [CB-1:0] ram_wdata, ram_rdata;

  logic          s_acc, out_free;
  logic [CB-1:0] w2;
  logic [SB-1:0] s2;
  logic [PB-1:0] q_val, d_val;

  // multiplier load for the next operation
  logic          ld_en;
  op_e           ld_op;
  logic [XB-1:0] ld_mc;
  logic [PB-1:0] ld_mp;
  logic [NW-1:0] ld_len;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign w2    = n_q - w1_q;
  assign s2    = s_q - s1_q;
  assign q_val = acc_q[PB-1:0];
  assign d_val = (p_q >= q_val) ? (p_q - q_val) : (q_val - p_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_raddr = (state_q == S_IDLE) ? s_axis_tdata : k_q;
    case (state_q)
      S_CLEAR: ram_we = 1'b1;
      S_INC: begin
        ram_we    = cnt_ok_q;
        ram_waddr = pix_q;
        ram_wdata = ram_rdata + CB'(1);
      end
      S_SRD: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    ld_en  = 1'b0;
    ld_op  = OP_P;
    ld_mc  = XB'(s1_q);
    ld_mp  = PB'(w2);
    ld_len = NW'(CB);
    if (state_q == S_SCHK) begin
      ld_en = (w1_q != '0) && (w1_q < n_q);
    end else if (state_q == S_NEXT) begin
      ld_en = 1'b1;
      case (op_q)
        OP_P: begin
          ld_op = OP_Q;
          ld_mc = XB'(s2);
          ld_mp = PB'(w1_q);
        end
        OP_Q: begin
          ld_op  = OP_NUM;
          ld_mc  = XB'(d_val);
          ld_mp  = d_val;
          ld_len = NW'(PB);
        end
        OP_NUM: begin
          ld_op = OP_DEN;
          ld_mc = XB'(w2);
          ld_mp = PB'(w1_q);
        end
        OP_DEN: begin
          ld_op  = OP_LHS;
          ld_mc  = XB'(num_q);
          ld_mp  = PB'(best_den_q);
          ld_len = NW'(DB);
        end
        OP_LHS: begin
          ld_op  = OP_RHS;
          ld_mc  = XB'(best_num_q);
          ld_mp  = PB'(den_q);
          ld_len = NW'(DB);
        end
        default: ld_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      op_q       <= OP_P;
      clr_q      <= '0;
      k_q        <= '0;
      n_q        <= '0;
      s_q        <= '0;
      w1_q       <= '0;
      s1_q       <= '0;
      best_q     <= '0;
      best_num_q <= '0;
      best_den_q <= DB'(1);
      mcnt_q     <= '0;
      last_q     <= 1'b0;
      cnt_ok_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + LB'(1);
          if (clr_q == otsu_pkg::MaxLevel) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            pix_q    <= s_axis_tdata;
            last_q   <= s_axis_tlast;
            cnt_ok_q <= (n_q < CountMax);
            state_q  <= S_INC;
          end
        end
        S_INC: begin
          if (cnt_ok_q) begin
            n_q <= n_q + CB'(1);
            s_q <= s_q + SB'(pix_q);
          end
          if (last_q) begin
            k_q        <= '0;
            w1_q       <= '0;
            s1_q       <= '0;
            best_q     <= '0;
            best_num_q <= '0;
            best_den_q <= DB'(1);
            state_q    <= S_SRD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SRD: state_q <= S_SACC;
        S_SACC: begin
          w1_q    <= w1_q + ram_rdata;
          s1_q    <= s1_q + SB'(k_q) * SB'(ram_rdata);
          state_q <= S_SCHK;
        end
        S_SCHK: state_q <= ld_en ? S_MUL : S_STEP;
        S_MUL: begin
          if (mp_q[0]) begin
            acc_q <= acc_q + mc_q;
          end
          mc_q   <= mc_q << 1;
          mp_q   <= mp_q >> 1;
          mcnt_q <= mcnt_q - NW'(1);
          if (mcnt_q == NW'(1)) begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          case (op_q)
            OP_P:   p_q   <= acc_q[PB-1:0];
            OP_NUM: num_q <= acc_q[NB-1:0];
            OP_DEN: den_q <= acc_q[DB-1:0];
            OP_LHS: lhs_q <= acc_q;
            OP_RHS: begin
              if (lhs_q > acc_q) begin
                best_num_q <= num_q;
                best_den_q <= den_q;
                best_q     <= k_q;
              end
            end
            default: p_q <= p_q;
          endcase
          state_q <= ld_en ? S_MUL : S_STEP;
        end
        S_STEP: begin
          k_q     <= k_q + LB'(1);
          state_q <= (k_q == otsu_pkg::MaxLevel) ? S_OUT : S_SRD;
        end
        S_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= best_q;
            n_q       <= '0;
            s_q       <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (ld_en) begin
        op_q   <= ld_op;
        mc_q   <= ld_mc;
        mp_q   <= ld_mp;
        acc_q  <= '0;
        mcnt_q <= ld_len;
      end
    end
  end

  otsu_ram #(
    .WIDTH(CB),
    .DEPTH(otsu_pkg::NumLevels)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  a_accept_to_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> state_q == S_INC) else $error("pixel word not followed by update");

  a_scan_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRD) |-> (ram_we && ram_wdata == '0)) else $error("scan bin not cleared");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (mcnt_q != '0)) else $error("multiplier count ran out");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_den_q != '0) else $error("best denominator is zero");

  a_out_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (m_valid_q && state_q == S_IDLE))
    else $error("result not presented");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for the Otsu threshold finder: short images, exact integer predictor.
module testbench;

  localparam int unsigned LevelBits = otsu_pkg::LevelBits;
  localparam int unsigned NumLevels = otsu_pkg::NumLevels;
  localparam int unsigned CountBits = 20;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam int unsigned CycleLimit = 300000000;
  localparam int unsigned DrainCycles = 400;

  // idling phases
  typedef enum logic [1:0] {
    PhFree, PhSendIdle, PhRecvStall, PhBoth
  } phase_e;

  typedef struct packed {
    logic [LevelBits-1:0] level;
    logic                 last;
    logic                 drain_first;  // hold off until every threshold is in
    phase_e               phase;
  } pixel_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  pixel_word_t pixel_words[$];
  logic [LevelBits-1:0] thresholds_due[$];
  int unsigned word_idx = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  bit stim_done = 1'b0;
  phase_e cur_phase = PhFree;

  // predictor state
  logic [CountBits-1:0]   hist[NumLevels];
  logic [CountBits-1:0]   n_pix;
  logic [CountBits+7:0]   s_int;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  otsu_threshold_finder #(.COUNT_BITS(CountBits)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Exact search: compare (W2*S1-W1*S2)^2/(W1*W2) by cross-multiplying.
  function automatic logic [LevelBits-1:0] otsu_pick();
    logic [255:0] w1, w2, s1, s2, p, q, d, num, den, bn, bd;
    logic [LevelBits-1:0] best;
    w1 = '0; s1 = '0; bn = '0; bd = 256'd1; best = '0;
    for (int k = 0; k < NumLevels; k++) begin
      w1 = w1 + hist[k];
      s1 = s1 + k * hist[k];
      if (w1 != 0 && w1 < n_pix) begin
        w2 = n_pix - w1;
        s2 = s_int - s1;
        p = w2 * s1;
        q = w1 * s2;
        d = (p >= q) ? p - q : q - p;
        num = d * d;
        den = w1 * w2;
        if (num * bd > bn * den) begin
          bn = num;
          bd = den;
          best = LevelBits'(k);
        end
      end
    end
    return best;
  endfunction

  task automatic clear_hist();
    foreach (hist[i]) hist[i] = '0;
    n_pix = '0;
    s_int = '0;
  endtask

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // one image: levels in [lo, min(lo+span, 255)]
  task automatic add_image(int unsigned npix, int unsigned lo, int unsigned span,
                           phase_e ph, bit drain);
    pixel_word_t w;
    int unsigned hi;
    hi = (lo + span > 255) ? 255 : lo + span;
    for (int unsigned i = 0; i < npix; i++) begin
      w.level = LevelBits'($urandom_range(hi, lo));
      w.last = (i == npix - 1);
      w.drain_first = drain && (i == 0);
      w.phase = ph;
      pixel_words.push_back(w);
    end
  endtask

  task automatic add_word(int unsigned lvl, bit last);
    pixel_word_t w;
    w.level = LevelBits'(lvl);
    w.last = last;
    w.drain_first = 1'b0;
    w.phase = PhFree;
    pixel_words.push_back(w);
  endtask

  initial begin
    int unsigned img, lo, span;
    phase_e ph;
    clear_hist();
    // directed: single pixels, extremes, uniform, two-level, tie
    add_word(0, 1);
    add_word(255, 1);
    add_word(77, 0); add_word(77, 0); add_word(77, 1);        // uniform
    add_word(0, 0); add_word(255, 0); add_word(255, 1);       // extremes
    add_word(0, 0); add_word(2, 1);                           // tie between 0 and 1
    add_word(10, 0); add_word(10, 0); add_word(200, 0); add_word(201, 1);
    add_word(128, 0); add_word(127, 1);
    // random images, mostly narrow so the scan stays short
    img = 0;
    while (pixel_words.size() < 1700) begin
      ph = phase_e'((img / 4) % 4);
      span = roll(8) ? 255 : $urandom_range(7, 0);
      lo = (span == 255) ? 0 : $urandom_range(255, 0);
      add_image($urandom_range(60, 1), lo, span, ph, img == 9);
      img++;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver and predictor
  always @(posedge clk_i) begin
    pixel_word_t w;
    int unsigned nxt;
    if (rst_ni) begin
      nxt = word_idx;
      if (s_axis_tvalid && s_axis_tready) begin
        w = pixel_words[word_idx];
        if (n_pix < CountMax) begin
          hist[w.level] = hist[w.level] + 1'b1;
          n_pix = n_pix + 1'b1;
          s_int = s_int + w.level;
        end
        if (w.last) begin
          thresholds_due.push_back(otsu_pick());
          clear_hist();
        end
        nxt = word_idx + 1;
        word_idx <= nxt;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (nxt < pixel_words.size()) begin
          w = pixel_words[nxt];
          cur_phase <= w.phase;
          if ((w.drain_first && thresholds_due.size() != 0) ||
              ((w.phase == PhSendIdle || w.phase == PhBoth) &&
               roll(w.phase == PhBoth ? 24 : 79))) begin
            s_axis_tvalid <= 1'b0;
          end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= w.level;
            s_axis_tlast <= w.last;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [LevelBits-1:0] exp_thr;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (thresholds_due.size() == 0) begin
          $display("%0t: unexpected threshold, expected none, actual %0d", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_thr = thresholds_due.pop_front();
          if (m_axis_tdata !== exp_thr) begin
            $display("%0t: threshold mismatch, expected %0d, actual %0d",
                     $time, exp_thr, m_axis_tdata);
            errors++;
          end
        end
      end
      case (cur_phase)
        PhRecvStall: m_axis_tready <= !roll(79);
        PhBoth:      m_axis_tready <= !roll(24);
        default:     m_axis_tready <= 1'b1;
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (thresholds_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
